// ===== sv/assert_macros.svh =====
// Assertion macros shared by the bitmap mask scan engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/bmse_pkg.sv =====
// Types, codes and helper functions of the bitmap mask scan engine.
package bmse_pkg;

  localparam int unsigned CoordW = 7;
  localparam int unsigned PointW = 8;

  typedef enum logic [2:0] {
    OpSet    = 3'd0,
    OpClear  = 3'd1,
    OpTest   = 3'd2,
    OpNext   = 3'd3,
    OpPrev   = 3'd4,
    OpFirst  = 3'd5,
    OpLast   = 3'd6,
    OpInvert = 3'd7
  } op_e;

  typedef enum logic {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSetup,
    StPoint,
    StScan,
    StInvert,
    StResp
  } state_e;

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [5:0] lowest_set(logic [63:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // Index of the highest set bit; zero for an empty word.
  function automatic logic [5:0] highest_set(logic [63:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ===== sv/bmse_if.sv =====
// Handshake channels of the bitmap mask scan engine: request, result, configuration.
interface bmse_req_if;
  logic               valid;
  logic               ready;
  bmse_pkg::op_e      op;
  logic [6:0]         x_coord;
  logic [6:0]         y_coord;

  modport source (output valid, op, x_coord, y_coord, input ready);
  modport sink   (input valid, op, x_coord, y_coord, output ready);
endinterface

interface bmse_res_if;
  logic              valid;
  logic              ready;
  logic              bit_value;
  logic              found;
  logic signed [7:0] point_x;
  logic signed [7:0] point_y;

  modport source (output valid, bit_value, found, point_x, point_y, input ready);
  modport sink   (input valid, bit_value, found, point_x, point_y, output ready);
endinterface

interface bmse_cfg_if;
  logic                 valid;
  logic                 ready;
  bmse_pkg::reg_idx_e   reg_idx;
  logic [6:0]           wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// ===== sv/bitmap_mask_scan_engine.sv =====
// Bitmap mask scan engine: 2-D bit mask with point access and raster-order search.
//
// The mask lives in a row memory of MAX_HEIGHT words of MAX_WIDTH bits with one
// read port and one write port. A small sequencer drives one row read and at
// most one row write per cycle through a shared mask-and-priority-encode unit.
// After reset the block runs a clearing pass, one row per cycle, before it
// raises req_i.ready. Configuration writes are taken throughout. One request
// is worked on at a time. Set, clear and test go from transfer to result valid
// through accept, setup, row read-modify-write and result, skipping the row
// step when the point lies outside the window. A search walks rows one at a
// time, up to the effective height (height_q saturated at MAX_HEIGHT). Invert
// rewrites each row of the effective height in turn. While the output register
// still holds an earlier result that has not transferred, the sequencer waits in
// its result state. The next request is taken in the cycle after the result
// moves to the output register, even while that result still waits.
`include "assert_macros.svh"

module bitmap_mask_scan_engine #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmse_cfg_if.sink    cfg_i,
  bmse_req_if.sink    req_i,
  bmse_res_if.source  res_o
);
  import bmse_pkg::*;

  localparam int unsigned AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [6:0] WCap = 7'(MAX_WIDTH);
  localparam logic [6:0] HCap = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);
  localparam logic [AW-1:0] LastRow = AW'(MAX_HEIGHT - 1);

  // Row memory
  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;

  // Control and working registers
  state_e       state_q, state_d;
  logic [6:0]   width_q, height_q;
  logic [AW-1:0] clr_q, clr_d;
  op_e          op_q;
  logic [6:0]   x_q, y_q;
  logic [6:0]   cur_q, cur_d;
  logic [7:0]   lim_q, lim_d;
  logic         first_q, first_d;
  logic         res_bit_q, res_bit_d;
  logic         res_found_q, res_found_d;
  logic [7:0]   res_px_q, res_px_d;
  logic [7:0]   res_py_q, res_py_d;
  logic         out_valid_q;
  logic         out_bit_q, out_found_q;
  logic [7:0]   out_px_q, out_py_q;

  logic [6:0]   eff_w, eff_h, last_h, nxt;
  logic [MAX_WIDTH-1:0] cm, fm, pt_sel, row_hits;
  logic [5:0]   lo_idx, hi_idx;
  logic         fwd, in_win, out_free, req_xfer, out_load;

  assign eff_w  = (width_q > WCap) ? WCap : width_q;
  assign eff_h  = (height_q > HCap) ? HCap : height_q;
  assign last_h = 7'(eff_h - 7'd1);

  assign fwd    = op_q inside {OpNext, OpFirst};
  assign in_win = (x_q < eff_w) && (y_q < eff_h);
  assign nxt    = fwd ? 7'(cur_q + 7'd1) : 7'(cur_q - 7'd1);

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      cm[i]     = (7'(i) < eff_w);
      fm[i]     = fwd ? (8'(i) >= lim_q) : (8'(i) < lim_q);
      pt_sel[i] = (7'(i) == x_q);
    end
  end

  // Shared row unit: window mask, start limit on the first row, encode
  assign row_hits = rdata_q & cm & (first_q ? fm : '1);
  assign lo_idx   = lowest_set(64'(row_hits));
  assign hi_idx   = highest_set(64'(row_hits));

  assign req_i.ready = (state_q == StIdle);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || res_o.ready;
  assign out_load    = (state_q == StResp) && out_free;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    lim_d       = lim_q;
    first_d     = first_q;
    res_bit_d   = res_bit_q;
    res_found_d = res_found_q;
    res_px_d    = res_px_q;
    res_py_d    = res_py_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(cur_q);
    mem_wdata   = rdata_q;
    mem_raddr   = AW'(cur_q);

    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == LastRow) begin
          state_d = StIdle;
        end else begin
          clr_d = AW'(clr_q + 1'b1);
        end
      end

      StIdle: begin
        if (req_xfer) state_d = StSetup;
      end

      StSetup: begin
        res_bit_d   = 1'b0;
        res_found_d = 1'b0;
        res_px_d    = '0;
        res_py_d    = '0;
        first_d     = 1'b1;
        case (op_q)
          OpSet, OpClear, OpTest: begin
            mem_raddr = AW'(y_q);
            state_d   = in_win ? StPoint : StResp;
          end
          OpNext, OpFirst: begin
            cur_d     = (op_q == OpNext) ? y_q : 7'd0;
            lim_d     = (op_q == OpNext) ? 8'({1'b0, x_q} + 8'd1) : 8'd0;
            mem_raddr = AW'(cur_d);
            if (cur_d >= eff_h) begin
              res_px_d = {1'b0, eff_w};
              res_py_d = {1'b0, eff_h};
              state_d  = StResp;
            end else begin
              state_d  = StScan;
            end
          end
          OpPrev, OpLast: begin
            if ((op_q == OpLast) || (y_q >= eff_h)) begin
              cur_d = last_h;
              lim_d = {1'b0, eff_w};
            end else begin
              cur_d = y_q;
              lim_d = (x_q < eff_w) ? {1'b0, x_q} : {1'b0, eff_w};
            end
            mem_raddr = AW'(cur_d);
            if (eff_h == 7'd0) begin
              res_px_d = '1;
              res_py_d = '1;
              state_d  = StResp;
            end else begin
              state_d  = StScan;
            end
          end
          default: begin
            cur_d     = 7'd0;
            mem_raddr = '0;
            state_d   = (eff_h == 7'd0) ? StResp : StInvert;
          end
        endcase
      end

      StPoint: begin
        mem_waddr = AW'(y_q);
        case (op_q)
          OpSet: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q | pt_sel;
          end
          OpClear: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q & ~pt_sel;
          end
          default: begin
            res_bit_d = |(rdata_q & pt_sel);
          end
        endcase
        state_d = StResp;
      end

      StScan: begin
        // Check the row read last cycle, prefetch the next one
        mem_raddr = AW'(nxt);
        if (|row_hits) begin
          res_found_d = 1'b1;
          res_px_d    = fwd ? {2'b00, lo_idx} : {2'b00, hi_idx};
          res_py_d    = {1'b0, cur_q};
          state_d     = StResp;
        end else if (fwd ? (cur_q == last_h) : (cur_q == 7'd0)) begin
          res_px_d = fwd ? {1'b0, eff_w} : '1;
          res_py_d = fwd ? {1'b0, eff_h} : '1;
          state_d  = StResp;
        end else begin
          cur_d   = nxt;
          first_d = 1'b0;
        end
      end

      StInvert: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q ^ cm;
        mem_raddr = AW'(7'(cur_q + 7'd1));
        if (cur_q == last_h) begin
          state_d = StResp;
        end else begin
          cur_d = 7'(cur_q + 7'd1);
        end
      end

      StResp: begin
        if (out_free) state_d = StIdle;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      width_q     <= 7'd64;
      height_q    <= 7'd64;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.reg_idx)
          RegWidth:  width_q  <= cfg_i.wdata;
          RegHeight: height_q <= cfg_i.wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q <= req_i.op;
      x_q  <= req_i.x_coord;
      y_q  <= req_i.y_coord;
    end
    cur_q       <= cur_d;
    lim_q       <= lim_d;
    first_q     <= first_d;
    res_bit_q   <= res_bit_d;
    res_found_q <= res_found_d;
    res_px_q    <= res_px_d;
    res_py_q    <= res_py_d;
    if (out_load) begin
      out_bit_q   <= res_bit_q;
      out_found_q <= res_found_q;
      out_px_q    <= res_px_q;
      out_py_q    <= res_py_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.bit_value = out_bit_q;
  assign res_o.found     = out_found_q;
  assign res_o.point_x   = out_px_q;
  assign res_o.point_y   = out_py_q;

  `ASSERT_NEVER(a_no_req_during_clear, clk_i, rst_ni, (state_q == StClear) && req_i.ready, "request taken during clearing pass")
  `ASSERT_PROP(a_scan_row_in_window, clk_i, rst_ni, (state_q == StScan) |-> (cur_q < eff_h), "scan row outside window")
  `ASSERT_PROP(a_hit_in_window, clk_i, rst_ni, ((state_q == StResp) && res_found_q) |-> (!res_px_q[7] && (res_px_q[6:0] < eff_w) && (res_py_q[6:0] < eff_h)), "search hit outside window")

endmodule

// ===== sim/bitmap_mask_scan_engine_tb.sv =====
// Self-checking testbench for the bitmap mask scan engine: point access, searches, window edges.
`timescale 1ns / 100ps

module bitmap_mask_scan_engine_tb;
  import bmse_pkg::*;

  localparam int RandomItems = 1020;
  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic              bit_value;
    logic              found;
    logic signed [7:0] point_x;
    logic signed [7:0] point_y;
  } scan_result_t;

  logic clk;
  logic rst_n;

  bmse_cfg_if cfg_if ();
  bmse_req_if req_if ();
  bmse_res_if res_if ();

  bitmap_mask_scan_engine u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Shadow copy of the mask and the window registers
  logic [63:0]  mask_bits [64];
  logic [6:0]   width_reg;
  logic [6:0]   height_reg;
  scan_result_t pending_results [$];

  int mismatch_count;
  int burst_left;
  int random_sent;
  int cycle_count;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int eff_size(logic [6:0] value);
    return (value > 7'd64) ? 64 : int'(value);
  endfunction

  function automatic logic [63:0] window_cols(int w);
    if (w >= 64) return '1;
    if (w <= 0) return '0;
    return (64'd1 << w) - 64'd1;
  endfunction

  // Raster-order scan forward from (sx, sy) inclusive; misses report (w, h)
  function automatic scan_result_t scan_forward(int sx, int sy, int w, int h);
    scan_result_t r;
    logic [63:0]  word;
    r = '0;
    r.point_x = 8'(w);
    r.point_y = 8'(h);
    for (int yy = sy; yy < h; yy++) begin
      word = mask_bits[yy] & window_cols(w);
      if (sx >= 64) word = '0;
      else if (sx > 0) word &= ~64'd0 << sx;
      if (word != '0) begin
        for (int i = 63; i >= 0; i--) begin
          if (word[i]) r.point_x = 8'(i);
        end
        r.point_y = 8'(yy);
        r.found = 1'b1;
        return r;
      end
      sx = 0;
    end
    return r;
  endfunction

  // Raster-order scan backward from (ex, ey) inclusive; misses report (-1, -1)
  function automatic scan_result_t scan_backward(int ex, int ey, int w);
    scan_result_t r;
    logic [63:0]  word;
    r = '0;
    r.point_x = -8'sd1;
    r.point_y = -8'sd1;
    for (int yy = ey; yy >= 0; yy--) begin
      if (ex >= 0) begin
        word = mask_bits[yy] & window_cols(w);
        if (ex < 63) word &= (64'd2 << ex) - 64'd1;
        if (word != '0) begin
          for (int i = 0; i < 64; i++) begin
            if (word[i]) r.point_x = 8'(i);
          end
          r.point_y = 8'(yy);
          r.found = 1'b1;
          return r;
        end
      end
      ex = w - 1;
    end
    return r;
  endfunction

  // Apply one request to the shadow mask and return its result
  function automatic scan_result_t predict_scan(op_e op, logic [6:0] x, logic [6:0] y);
    scan_result_t r;
    int           w;
    int           h;
    int           ex;
    int           ey;
    logic         in_win;
    r = '0;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    in_win = (int'(x) < w) && (int'(y) < h);
    case (op)
      OpSet:   if (in_win) mask_bits[y][x] = 1'b1;
      OpClear: if (in_win) mask_bits[y][x] = 1'b0;
      OpTest:  if (in_win) r.bit_value = mask_bits[y][x];
      OpNext:  r = scan_forward(int'(x) + 1, int'(y), w, h);
      OpPrev: begin
        if (int'(y) >= h) begin
          ey = h - 1;
          ex = w - 1;
        end else begin
          ey = int'(y);
          ex = int'(x) - 1;
          if (ex > w - 1) ex = w - 1;
        end
        r = scan_backward(ex, ey, w);
      end
      OpFirst: r = scan_forward(0, 0, w, h);
      OpLast:  r = scan_backward(w - 1, h - 1, w);
      OpInvert: begin
        for (int i = 0; i < h; i++) mask_bits[i] ^= window_cols(w);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    scan_result_t want;
    scan_result_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{res_if.bit_value, res_if.found, res_if.point_x, res_if.point_y};
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: bit_value=%0d found=%0d point=(%0d,%0d)",
                   got.bit_value, got.found, got.point_x, got.point_y);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.bit_value !== want.bit_value || got.found !== want.found ||
            got.point_x !== want.point_x || got.point_y !== want.point_y) begin
          if (mismatch_count < 10)
            $display("mismatch: expected bit_value=%0d found=%0d point=(%0d,%0d), %s%0d %s%0d %s(%0d,%0d)",
                     want.bit_value, want.found, want.point_x, want.point_y,
                     "got bit_value=", got.bit_value, "found=", got.found,
                     "point=", got.point_x, got.point_y);
          mismatch_count++;
        end
      end
    end
  end

  // Result-side backpressure under a stall pattern picked at random from four modes
  initial begin
    int stall_cnt;
    int stall_mode;
    stall_cnt = 0;
    stall_mode = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      stall_cnt++;
      if (stall_cnt % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 2) != 0);
        2:       res_if.ready <= (stall_cnt % 5 >= 2);
        default: res_if.ready <= (stall_cnt % 24 >= 16);
      endcase
    end
  end

  task automatic send_request(input op_e op, input logic [6:0] x, input logic [6:0] y);
    int           gap;
    scan_result_t expected;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.x_coord <= x;
    req_if.y_coord <= y;
    do @(posedge clk); while (!req_if.ready);
    expected = predict_scan(op, x, y);
    pending_results = {pending_results, expected};
  endtask

  // Hold requests until every expected result has come back
  task automatic wait_all_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input reg_idx_e idx, input logic [6:0] value);
    wait_all_results();
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == RegWidth) width_reg = value;
    else height_reg = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 15))
      0:       return 7'd0;
      1, 2:    return 7'd1;
      3:       return 7'd64;
      4:       return 7'd127;
      5:       return 7'($urandom_range(65, 126));
      6, 7, 8: return 7'($urandom_range(21, 63));
      default: return 7'($urandom_range(2, 20));
    endcase
  endfunction

  // Set, clear and test at the corners of the full mask, and outside it
  task automatic test_point_access();
    send_request(OpSet, 7'd0, 7'd0);
    send_request(OpSet, 7'd63, 7'd63);
    send_request(OpSet, 7'd63, 7'd0);
    send_request(OpSet, 7'd127, 7'd127);
    send_request(OpTest, 7'd63, 7'd63);
    send_request(OpTest, 7'd64, 7'd5);
    send_request(OpClear, 7'd63, 7'd63);
    send_request(OpTest, 7'd63, 7'd63);
  endtask

  // Searches with wrap to the next row, misses, and clamped prev starts
  task automatic test_searches();
    send_request(OpSet, 7'd0, 7'd63);
    send_request(OpFirst, 7'd0, 7'd0);
    send_request(OpLast, 7'd0, 7'd0);
    send_request(OpNext, 7'd0, 7'd0);
    send_request(OpNext, 7'd63, 7'd0);
    send_request(OpNext, 7'd0, 7'd63);
    send_request(OpNext, 7'd3, 7'd100);
    send_request(OpPrev, 7'd0, 7'd63);
    send_request(OpPrev, 7'd127, 7'd127);
    send_request(OpPrev, 7'd0, 7'd0);
    send_request(OpPrev, 7'd127, 7'd0);
  endtask

  // Small, empty and saturated windows; invert touches the window only
  task automatic test_window_edges();
    write_config(RegWidth, 7'd3);
    write_config(RegHeight, 7'd2);
    send_request(OpInvert, 7'd0, 7'd0);
    send_request(OpLast, 7'd0, 7'd0);
    send_request(OpTest, 7'd63, 7'd0);
    write_config(RegWidth, 7'd0);
    send_request(OpFirst, 7'd0, 7'd0);
    send_request(OpPrev, 7'd5, 7'd1);
    write_config(RegWidth, 7'd127);
    write_config(RegHeight, 7'd0);
    send_request(OpLast, 7'd0, 7'd0);
    write_config(RegHeight, 7'd127);
    send_request(OpLast, 7'd0, 7'd0);
    send_request(OpInvert, 7'd0, 7'd0);
    write_config(RegWidth, 7'd1);
    write_config(RegHeight, 7'd1);
    send_request(OpTest, 7'd0, 7'd0);
  endtask

  // Phases of random traffic, each under a fresh window, mostly inside it
  task automatic test_random_traffic();
    int         w;
    int         h;
    int         pick;
    op_e        op;
    logic [6:0] x;
    logic [6:0] y;
    while (random_sent < RandomItems) begin
      write_config(RegWidth, pick_size());
      write_config(RegHeight, pick_size());
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      repeat ($urandom_range(30, 90)) begin
        pick = $urandom_range(0, 99);
        if (pick < 28) op = OpSet;
        else if (pick < 42) op = OpClear;
        else if (pick < 62) op = OpTest;
        else if (pick < 74) op = OpNext;
        else if (pick < 86) op = OpPrev;
        else if (pick < 91) op = OpFirst;
        else if (pick < 96) op = OpLast;
        else op = OpInvert;
        x = 7'($urandom_range(0, 127));
        y = 7'($urandom_range(0, 127));
        if (w > 0 && h > 0 && $urandom_range(0, 9) < 8) begin
          x = 7'($urandom_range(0, w - 1));
          y = 7'($urandom_range(0, h - 1));
        end
        send_request(op, x, y);
        random_sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    req_if.valid   <= 1'b0;
    req_if.op      <= OpSet;
    req_if.x_coord <= '0;
    req_if.y_coord <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.reg_idx <= RegWidth;
    cfg_if.wdata   <= '0;
    for (int i = 0; i < 64; i++) mask_bits[i] = '0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    mismatch_count = 0;
    burst_left = 0;
    random_sent = 0;
    cycle_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_point_access();
    test_searches();
    test_window_edges();
    test_random_traffic();

    wait_all_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
